/* rtl/vr2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vr2d_pkg: shared types and constants for the 2D vector rotator
// Holds the pipeline control word, quadrant and angle-unit codes, the
// angle-to-phase scale factors and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vr2d_pkg;

  // Control word that travels alongside every pipeline stage.
  typedef struct packed {
    logic       vld;
    logic [1:0] quad;
  } ctl_t;

  // Quarter-turn codes applied after the CORDIC.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Angle unit select.
  localparam logic MODE_DEG = 1'b0;
  localparam logic MODE_RAD = 1'b1;

  // Sine and cosine carry 30 fraction bits (Q2.30).
  localparam int unsigned TRIG_FRAC = 30;

  // CORDIC start value: reciprocal of the CORDIC gain in Q2.30.
  localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

  // Scale from angle to phase, 2^64 per full turn:
  // 2^64 / (2*pi) for radians and 2^64 / 360 for degrees.
  localparam logic [63:0] K_RAD = 64'h28BE60DB9391054A;
  localparam logic [63:0] K_DEG = 64'd51240955760304310;

  // Largest number of CORDIC cells the arctangent table supports.
  localparam int unsigned MAX_CELLS = 32;

  // Arctangent of 2^-i in phase units (2^32 per turn), rounded.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    begin
      case (idx)
        5'd0:  val = 32'd536870912;
        5'd1:  val = 32'd316933406;
        5'd2:  val = 32'd167458907;
        5'd3:  val = 32'd85004756;
        5'd4:  val = 32'd42667331;
        5'd5:  val = 32'd21354465;
        5'd6:  val = 32'd10679838;
        5'd7:  val = 32'd5340245;
        5'd8:  val = 32'd2670163;
        5'd9:  val = 32'd1335087;
        5'd10: val = 32'd667544;
        5'd11: val = 32'd333772;
        5'd12: val = 32'd166886;
        5'd13: val = 32'd83443;
        5'd14: val = 32'd41722;
        5'd15: val = 32'd20861;
        5'd16: val = 32'd10430;
        5'd17: val = 32'd5215;
        5'd18: val = 32'd2608;
        5'd19: val = 32'd1304;
        5'd20: val = 32'd652;
        5'd21: val = 32'd326;
        5'd22: val = 32'd163;
        5'd23: val = 32'd81;
        5'd24: val = 32'd41;
        5'd25: val = 32'd20;
        5'd26: val = 32'd10;
        5'd27: val = 32'd5;
        5'd28: val = 32'd3;
        5'd29: val = 32'd1;
        5'd30: val = 32'd1;
        5'd31: val = 32'd0;
        default: val = 32'd0;
      endcase
      return val;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/vr2d_phase.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vr2d_phase: angle to phase conversion
// Scales the fixed-point angle to a 32-bit phase (2^32 per turn) with a
// rounded constant multiply split into four partial products, then splits
// the phase into a quarter-turn code and an octant-centered residual.
// Three register stages.
// ----------------------------------------------------------------------------
module vr2d_phase #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  vr2d_pkg::ctl_t                ctl_i,
  input  wire signed [COORD_WIDTH-1:0]  x_i,
  input  wire signed [COORD_WIDTH-1:0]  y_i,
  input  wire signed [COORD_WIDTH-1:0]  angle_i,
  input  wire                           mode_i,
  output vr2d_pkg::ctl_t                ctl_o,
  output logic signed [COORD_WIDTH-1:0] x_o,
  output logic signed [COORD_WIDTH-1:0] y_o,
  output logic signed [31:0]            z_o
);

  localparam int ALO = COORD_WIDTH / 2;     // low angle slice, unsigned
  localparam int AH  = COORD_WIDTH - ALO;   // high angle slice, signed
  localparam int SH  = 32 + FRAC_BITS;      // phase sits at bit SH
  localparam int PW  = SH + 32;             // product bits that matter
  localparam int LW  = ALO + 32;            // low-slice product width
  localparam int HW  = AH + 33;             // high-slice product width
  localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (SH - 1);

  // Stage 1: partial products of angle times scale.
  logic [63:0]          k_sel;
  logic [ALO-1:0]       a_lo;
  logic signed [AH-1:0] a_hi;
  logic [LW-1:0]        pp_ll_nxt, pp_lh_nxt, pp_ll_r, pp_lh_r;
  logic signed [HW-1:0] pp_hl_nxt, pp_hh_nxt, pp_hl_r, pp_hh_r;
  vr2d_pkg::ctl_t       ctl1_r;
  logic signed [COORD_WIDTH-1:0] x1_r, y1_r;

  always_comb begin
    k_sel     = (mode_i == vr2d_pkg::MODE_RAD) ? vr2d_pkg::K_RAD : vr2d_pkg::K_DEG;
    a_lo      = angle_i[ALO-1:0];
    a_hi      = angle_i[COORD_WIDTH-1:ALO];
    pp_ll_nxt = a_lo * k_sel[31:0];
    pp_lh_nxt = a_lo * k_sel[63:32];
    pp_hl_nxt = a_hi * $signed({1'b0, k_sel[31:0]});
    pp_hh_nxt = a_hi * $signed({1'b0, k_sel[63:32]});
  end

  // Stage 2: align the partial products into two sums; rounding goes in here.
  logic [PW-1:0] hl_ext, hh_ext;
  logic [PW-1:0] s1_nxt, s2_nxt, s1_r, s2_r;
  vr2d_pkg::ctl_t ctl2_r;
  logic signed [COORD_WIDTH-1:0] x2_r, y2_r;

  always_comb begin
    hl_ext = {{(PW-HW){pp_hl_r[HW-1]}}, pp_hl_r};
    hh_ext = {{(PW-HW){pp_hh_r[HW-1]}}, pp_hh_r};
    s1_nxt = {{(PW-LW){1'b0}}, pp_ll_r} + ({{(PW-LW){1'b0}}, pp_lh_r} << 32);
    s2_nxt = (hl_ext << ALO) + (hh_ext << (ALO + 32)) + HALF;
  end

  // Stage 3: final add, phase pick, quadrant and residual.
  // The residual is the low 30 phase bits taken as a signed value.
  logic [PW-1:0]  sum;
  logic [31:0]    phase;
  vr2d_pkg::ctl_t ctl3_nxt, ctl3_r;
  logic signed [31:0] z_nxt, z_r;
  logic signed [COORD_WIDTH-1:0] x3_r, y3_r;

  always_comb begin
    sum           = s1_r + s2_r;
    phase         = sum[SH+31:SH];
    ctl3_nxt.vld  = ctl2_r.vld;
    ctl3_nxt.quad = phase[31:30] + {1'b0, phase[29]};
    z_nxt         = {{2{phase[29]}}, phase[29:0]};
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl3_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
      x1_r    <= x_i;
      y1_r    <= y_i;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      z_r     <= z_nxt;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
    end
  end

  assign ctl_o = ctl3_r;
  assign x_o   = x3_r;
  assign y_o   = y3_r;
  assign z_o   = z_r;

endmodule
`default_nettype wire

/* rtl/vr2d_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vr2d_cell: one CORDIC rotation cell
// Performs one micro-rotation by the arctangent of 2^-IDX toward a zero
// residual angle and passes the vector and its side data to the next cell.
// ----------------------------------------------------------------------------
module vr2d_cell #(
  parameter int COORD_WIDTH = 32,
  parameter int IDX         = 0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  vr2d_pkg::ctl_t                ctl_i,
  input  wire signed [COORD_WIDTH-1:0]  x_i,
  input  wire signed [COORD_WIDTH-1:0]  y_i,
  input  wire signed [31:0]             cx_i,
  input  wire signed [31:0]             sy_i,
  input  wire signed [31:0]             z_i,
  output vr2d_pkg::ctl_t                ctl_o,
  output logic signed [COORD_WIDTH-1:0] x_o,
  output logic signed [COORD_WIDTH-1:0] y_o,
  output logic signed [31:0]            cx_o,
  output logic signed [31:0]            sy_o,
  output logic signed [31:0]            z_o
);

  localparam logic signed [31:0] ATAN = vr2d_pkg::atan_turn(5'(IDX));

  logic signed [31:0] cx_nxt, sy_nxt, z_nxt, cx_r, sy_r, z_r;
  logic signed [COORD_WIDTH-1:0] x_r, y_r;
  vr2d_pkg::ctl_t ctl_r;

  // Rotate toward zero residual: direction follows the residual's sign.
  always_comb begin
    if (!z_i[31]) begin
      cx_nxt = cx_i - (sy_i >>> IDX);
      sy_nxt = sy_i + (cx_i >>> IDX);
      z_nxt  = z_i - ATAN;
    end else begin
      cx_nxt = cx_i + (sy_i >>> IDX);
      sy_nxt = sy_i - (cx_i >>> IDX);
      z_nxt  = z_i + ATAN;
    end
  end

  // Control word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= cx_nxt;
      sy_r <= sy_nxt;
      z_r  <= z_nxt;
      x_r  <= x_i;
      y_r  <= y_i;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign cx_o  = cx_r;
  assign sy_o  = sy_r;
  assign z_o   = z_r;

endmodule
`default_nettype wire

/* rtl/vr2d_mix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vr2d_mix: quadrant fix-up and vector product
// Turns the CORDIC cosine and sine by the quarter-turn code, forms
// x*cos - y*sin and x*sin + y*cos from split partial products, rounds
// half up at the trig fraction and saturates to the coordinate range.
// Four register stages.
// ----------------------------------------------------------------------------
module vr2d_mix #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  vr2d_pkg::ctl_t                ctl_i,
  input  wire signed [COORD_WIDTH-1:0]  x_i,
  input  wire signed [COORD_WIDTH-1:0]  y_i,
  input  wire signed [31:0]             cx_i,
  input  wire signed [31:0]             sy_i,
  output logic                          vld_o,
  output logic [COORD_WIDTH-1:0]        x_o,
  output logic [COORD_WIDTH-1:0]        y_o
);

  localparam int ALO = COORD_WIDTH / 2;     // low coordinate slice, unsigned
  localparam int AH  = COORD_WIDTH - ALO;   // high coordinate slice, signed
  localparam int LW  = ALO + 33;
  localparam int HW  = AH + 32;
  localparam int FW  = COORD_WIDTH + 32;    // full single product
  localparam int MW  = COORD_WIDTH + 33;    // sum of two products
  localparam int TF  = vr2d_pkg::TRIG_FRAC;
  localparam logic [MW-1:0] HALF = {{(MW-1){1'b0}}, 1'b1} << (TF - 1);
  localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Stage Q: quarter-turn swap of cosine and sine.
  logic signed [31:0] c_nxt, s_nxt, c_r, s_r;
  logic signed [COORD_WIDTH-1:0] xq_r, yq_r;
  logic vq_r;

  always_comb begin
    case (ctl_i.quad)
      vr2d_pkg::QUAD_0: begin c_nxt = cx_i;  s_nxt = sy_i;  end
      vr2d_pkg::QUAD_1: begin c_nxt = -sy_i; s_nxt = cx_i;  end
      vr2d_pkg::QUAD_2: begin c_nxt = -cx_i; s_nxt = -sy_i; end
      vr2d_pkg::QUAD_3: begin c_nxt = sy_i;  s_nxt = -cx_i; end
      default:          begin c_nxt = cx_i;  s_nxt = sy_i;  end
    endcase
  end

  // Stage M1: eight partial products over the coordinate halves.
  logic [ALO-1:0]       xl, yl;
  logic signed [AH-1:0] xh, yh;
  logic signed [LW-1:0] xlc_nxt, xls_nxt, ylc_nxt, yls_nxt;
  logic signed [LW-1:0] xlc_r, xls_r, ylc_r, yls_r;
  logic signed [HW-1:0] xhc_nxt, xhs_nxt, yhc_nxt, yhs_nxt;
  logic signed [HW-1:0] xhc_r, xhs_r, yhc_r, yhs_r;
  logic v1_r;

  always_comb begin
    xl      = xq_r[ALO-1:0];
    yl      = yq_r[ALO-1:0];
    xh      = xq_r[COORD_WIDTH-1:ALO];
    yh      = yq_r[COORD_WIDTH-1:ALO];
    xlc_nxt = $signed({1'b0, xl}) * c_r;
    xls_nxt = $signed({1'b0, xl}) * s_r;
    ylc_nxt = $signed({1'b0, yl}) * c_r;
    yls_nxt = $signed({1'b0, yl}) * s_r;
    xhc_nxt = xh * c_r;
    xhs_nxt = xh * s_r;
    yhc_nxt = yh * c_r;
    yhs_nxt = yh * s_r;
  end

  // Stage M2: rebuild the four full products.
  logic [FW-1:0] xc_nxt, xs_nxt, yc_nxt, ys_nxt;
  logic [FW-1:0] xc_r, xs_r, yc_r, ys_r;
  logic v2_r;

  always_comb begin
    xc_nxt = ({xhc_r, {ALO{1'b0}}}) + {{(FW-LW){xlc_r[LW-1]}}, xlc_r};
    xs_nxt = ({xhs_r, {ALO{1'b0}}}) + {{(FW-LW){xls_r[LW-1]}}, xls_r};
    yc_nxt = ({yhc_r, {ALO{1'b0}}}) + {{(FW-LW){ylc_r[LW-1]}}, ylc_r};
    ys_nxt = ({yhs_r, {ALO{1'b0}}}) + {{(FW-LW){yls_r[LW-1]}}, yls_r};
  end

  // Stage M3: combine products and add the rounding half.
  logic [MW-1:0] xo_nxt, yo_nxt, xo_r, yo_r;
  logic v3_r;

  always_comb begin
    xo_nxt = {xc_r[FW-1], xc_r} - {ys_r[FW-1], ys_r} + HALF;
    yo_nxt = {xs_r[FW-1], xs_r} + {yc_r[FW-1], yc_r} + HALF;
  end

  // Drop the trig fraction and clamp to the coordinate range.
  function automatic logic [COORD_WIDTH-1:0] clamp(input logic [MW-1:0] v);
    logic [MW-COORD_WIDTH-TF:0] top;
    begin
      top = v[MW-1:COORD_WIDTH+TF-1];
      if (&top || ~|top) begin
        return v[COORD_WIDTH+TF-1:TF];
      end else if (v[MW-1]) begin
        return SAT_MIN;
      end else begin
        return SAT_MAX;
      end
    end
  endfunction

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      vq_r <= ctl_i.vld;
      v1_r <= vq_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      c_r   <= c_nxt;
      s_r   <= s_nxt;
      xq_r  <= x_i;
      yq_r  <= y_i;
      xlc_r <= xlc_nxt;
      xls_r <= xls_nxt;
      ylc_r <= ylc_nxt;
      yls_r <= yls_nxt;
      xhc_r <= xhc_nxt;
      xhs_r <= xhs_nxt;
      yhc_r <= yhc_nxt;
      yhs_r <= yhs_nxt;
      xc_r  <= xc_nxt;
      xs_r  <= xs_nxt;
      yc_r  <= yc_nxt;
      ys_r  <= ys_nxt;
      xo_r  <= xo_nxt;
      yo_r  <= yo_nxt;
    end
  end

  assign vld_o = v3_r;
  assign x_o   = clamp(xo_r);
  assign y_o   = clamp(yo_r);

endmodule
`default_nettype wire

/* rtl/vector_rotate_2d_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one beat per cycle while in_ready is high; every stage advances
// together, one CORDIC cell per stage, so the cell chain length sets the
// latency, not the rate. in_ready drops only while the skid register holds
// a beat behind a stalled output. Reset (synchronous, active low) clears
// all valid bits; no state is kept between beats.
// ----------------------------------------------------------------------------
// vector_rotate_2d_unit: 2D vector rotation by a fixed-point angle
// Converts the angle to a phase, runs a chain of CORDIC cells for cosine and
// sine, and forms the rounded, saturated rotated vector. Output register
// plus skid register on the result side.
// ----------------------------------------------------------------------------
module vector_rotate_2d_unit #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 20
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire signed [COORD_WIDTH-1:0] in_x_in,
  input  wire signed [COORD_WIDTH-1:0] in_y_in,
  input  wire signed [COORD_WIDTH-1:0] in_angle_in,
  input  wire                          in_mode,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [COORD_WIDTH-1:0]       out_x_out,
  output logic [COORD_WIDTH-1:0]       out_y_out
);

  localparam int NC = (CORDIC_STAGES > vr2d_pkg::MAX_CELLS) ?
                      vr2d_pkg::MAX_CELLS : CORDIC_STAGES;

  // The whole pipeline moves while the skid register is empty.
  logic en;
  logic skid_vld_r;
  assign en       = !skid_vld_r;
  assign in_ready = en;

  // Phase front end.
  vr2d_pkg::ctl_t in_ctl;
  assign in_ctl.vld  = in_valid;
  assign in_ctl.quad = vr2d_pkg::QUAD_0;

  vr2d_pkg::ctl_t                ch_ctl [0:NC];
  logic signed [COORD_WIDTH-1:0] ch_x   [0:NC];
  logic signed [COORD_WIDTH-1:0] ch_y   [0:NC];
  logic signed [31:0]            ch_cx  [0:NC];
  logic signed [31:0]            ch_sy  [0:NC];
  logic signed [31:0]            ch_z   [0:NC-1];

  vr2d_phase #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (in_ctl),
    .x_i     (in_x_in),
    .y_i     (in_y_in),
    .angle_i (in_angle_in),
    .mode_i  (in_mode),
    .ctl_o   (ch_ctl[0]),
    .x_o     (ch_x[0]),
    .y_o     (ch_y[0]),
    .z_o     (ch_z[0])
  );

  assign ch_cx[0] = vr2d_pkg::INV_GAIN_Q30;
  assign ch_sy[0] = '0;

  // CORDIC cell chain; the last cell's residual is not needed.
  genvar gi;
  generate
    for (gi = 0; gi < NC; gi++) begin : g_cell
      if (gi < NC - 1) begin : g_mid
        vr2d_cell #(
          .COORD_WIDTH (COORD_WIDTH),
          .IDX         (gi)
        ) u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .en    (en),
          .ctl_i (ch_ctl[gi]),
          .x_i   (ch_x[gi]),
          .y_i   (ch_y[gi]),
          .cx_i  (ch_cx[gi]),
          .sy_i  (ch_sy[gi]),
          .z_i   (ch_z[gi]),
          .ctl_o (ch_ctl[gi+1]),
          .x_o   (ch_x[gi+1]),
          .y_o   (ch_y[gi+1]),
          .cx_o  (ch_cx[gi+1]),
          .sy_o  (ch_sy[gi+1]),
          .z_o   (ch_z[gi+1])
        );
      end else begin : g_last
        vr2d_cell #(
          .COORD_WIDTH (COORD_WIDTH),
          .IDX         (gi)
        ) u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .en    (en),
          .ctl_i (ch_ctl[gi]),
          .x_i   (ch_x[gi]),
          .y_i   (ch_y[gi]),
          .cx_i  (ch_cx[gi]),
          .sy_i  (ch_sy[gi]),
          .z_i   (ch_z[gi]),
          .ctl_o (ch_ctl[gi+1]),
          .x_o   (ch_x[gi+1]),
          .y_o   (ch_y[gi+1]),
          .cx_o  (ch_cx[gi+1]),
          .sy_o  (ch_sy[gi+1]),
          .z_o   ()
        );
      end
    end
  endgenerate

  // Back end: quadrant fix-up, products, rounding and saturation.
  logic                   mix_vld;
  logic [COORD_WIDTH-1:0] mix_x, mix_y;

  vr2d_mix #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ch_ctl[NC]),
    .x_i   (ch_x[NC]),
    .y_i   (ch_y[NC]),
    .cx_i  (ch_cx[NC]),
    .sy_i  (ch_sy[NC]),
    .vld_o (mix_vld),
    .x_o   (mix_x),
    .y_o   (mix_y)
  );

  // Output register with a skid register behind it.
  logic                   out_valid_r, out_valid_nxt;
  logic [COORD_WIDTH-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                   skid_vld_nxt;
  logic [COORD_WIDTH-1:0] skid_x_r, skid_x_nxt, skid_y_r, skid_y_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    skid_vld_nxt  = skid_vld_r;
    skid_x_nxt    = skid_x_r;
    skid_y_nxt    = skid_y_r;
    if (skid_vld_r) begin
      // Pipeline is frozen; drain the skid beat once the output is taken.
      if (out_ready) begin
        out_x_nxt    = skid_x_r;
        out_y_nxt    = skid_y_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_nxt = mix_vld;
      out_x_nxt     = mix_x;
      out_y_nxt     = mix_y;
    end else if (mix_vld) begin
      skid_vld_nxt = 1'b1;
      skid_x_nxt   = mix_x;
      skid_y_nxt   = mix_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    skid_x_r <= skid_x_nxt;
    skid_y_r <= skid_y_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_x_out = out_x_r;
  assign out_y_out = out_y_r;

  // The skid register only fills behind a held output beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid register holds a beat while the output is empty");

  // A skid beat appears only when the output was stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid register filled without an output stall");

  // Draining the skid leaves a valid beat on the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_ready |=> out_valid_r && !skid_vld_r)
    else $error("skid beat lost while draining");

  // A frozen pipeline keeps its last-stage beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    !en && mix_vld |=> mix_vld)
    else $error("pipeline beat dropped while stalled");

endmodule
`default_nettype wire

/* test/vr2d_rotation_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr2d_rotation_check: result checker for the 2D vector rotator
// Watches both handshake channels. Every accepted input beat is rotated by an
// independent fixed-point model (angle to phase, CORDIC, quarter-turn swap,
// rounding and saturation), and every accepted output beat is compared field
// by field with the oldest rotation still outstanding.
// ----------------------------------------------------------------------------
module vr2d_rotation_check #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 20
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire signed [COORD_WIDTH-1:0] in_x_in,
  input  wire signed [COORD_WIDTH-1:0] in_y_in,
  input  wire signed [COORD_WIDTH-1:0] in_angle_in,
  input  wire                          in_mode,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire        [COORD_WIDTH-1:0] out_x_out,
  input  wire        [COORD_WIDTH-1:0] out_y_out,
  output int                           mismatches,
  output int                           rotations_pending,
  output int                           rotations_checked
);

  localparam int PHASE_SHIFT = 32 + FRAC_BITS;
  localparam int NUM_CELLS   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  // Arctangent of 2^-i in phase units, 2^32 per full turn.
  localparam longint ATAN_PHASE [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
  } rotated_vec_t;

  rotated_vec_t expected_rotations[$];

  // Round a Q2.30-scaled sum back to the coordinate format and clamp it.
  function automatic logic [COORD_WIDTH-1:0] round_clamp(input logic signed [127:0] acc);
    logic signed [127:0] val;
    logic signed [127:0] maxv;
    logic signed [127:0] minv;
    maxv = (128'sd1 <<< (COORD_WIDTH - 1)) - 128'sd1;
    minv = -maxv - 128'sd1;
    val  = (acc + (128'sd1 <<< (vr2d_pkg::TRIG_FRAC - 1))) >>> vr2d_pkg::TRIG_FRAC;
    if (val > maxv) begin
      val = maxv;
    end else if (val < minv) begin
      val = minv;
    end
    return val[COORD_WIDTH-1:0];
  endfunction

  // Rotate one vector by its angle, bit-exact to the fixed-point definition.
  function automatic rotated_vec_t rotate_vector(
    input logic signed [COORD_WIDTH-1:0] xv,
    input logic signed [COORD_WIDTH-1:0] yv,
    input logic signed [COORD_WIDTH-1:0] av,
    input logic                          unit
  );
    logic signed [127:0] angle_w;
    logic signed [127:0] scale_w;
    logic signed [127:0] prod;
    logic signed [127:0] x_w;
    logic signed [127:0] y_w;
    logic signed [127:0] cos_w;
    logic signed [127:0] sin_w;
    logic [31:0]         phase;
    logic [31:0]         resid;
    logic [1:0]          quad;
    longint              z;
    longint              cx;
    longint              sy;
    longint              dx;
    longint              dy;
    longint              cosv;
    longint              sinv;
    rotated_vec_t        res;
    angle_w = av;
    scale_w = $signed({64'd0, (unit == vr2d_pkg::MODE_RAD) ? vr2d_pkg::K_RAD
                                                           : vr2d_pkg::K_DEG});
    prod    = angle_w * scale_w + (128'sd1 <<< (PHASE_SHIFT - 1));
    phase   = prod[PHASE_SHIFT +: 32];

    // Octant-centered residual and the quarter turn it leaves behind.
    quad  = 2'((phase + 32'h2000_0000) >> 30);
    resid = phase - {quad, 30'd0};
    z     = longint'($signed(resid));

    cx = longint'(vr2d_pkg::INV_GAIN_Q30);
    sy = 0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx;
        sy += dy;
        z  -= ATAN_PHASE[i];
      end else begin
        cx += dx;
        sy -= dy;
        z  += ATAN_PHASE[i];
      end
    end

    case (quad)
      vr2d_pkg::QUAD_1: begin
        cosv = -sy;
        sinv = cx;
      end
      vr2d_pkg::QUAD_2: begin
        cosv = -cx;
        sinv = -sy;
      end
      vr2d_pkg::QUAD_3: begin
        cosv = sy;
        sinv = -cx;
      end
      default: begin
        cosv = cx;
        sinv = sy;
      end
    endcase

    x_w   = xv;
    y_w   = yv;
    cos_w = cosv;
    sin_w = sinv;
    res.x = round_clamp(x_w * cos_w - y_w * sin_w);
    res.y = round_clamp(x_w * sin_w + y_w * cos_w);
    return res;
  endfunction

  // Predict on every input beat and compare on every output beat.
  always @(posedge clk) begin
    rotated_vec_t exp_vec;
    if (!rst_n) begin
      expected_rotations.delete();
      mismatches        = 0;
      rotations_checked = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rotations.push_back(rotate_vector(in_x_in, in_y_in, in_angle_in, in_mode));
      end
      if (out_valid && out_ready) begin
        if (expected_rotations.size() == 0) begin
          $display("%0t: unexpected result beat x=%0d y=%0d", $time,
                   $signed(out_x_out), $signed(out_y_out));
          mismatches++;
        end else begin
          exp_vec = expected_rotations.pop_front();
          rotations_checked++;
          if (out_x_out !== exp_vec.x) begin
            $display("%0t: x_out mismatch, expected %0d, actual %0d", $time,
                     $signed(exp_vec.x), $signed(out_x_out));
            mismatches++;
          end
          if (out_y_out !== exp_vec.y) begin
            $display("%0t: y_out mismatch, expected %0d, actual %0d", $time,
                     $signed(exp_vec.y), $signed(out_y_out));
            mismatches++;
          end
        end
      end
    end
    rotations_pending = expected_rotations.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for vector_rotate_2d_unit
// Drives directed corner vectors and then random vectors in degrees and
// radians through four flow-control phases, and reports the verdict from the
// rotation checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 20;
  localparam int RANDOM_BEATS  = 850;
  localparam int DRAIN_CYCLES  = CORDIC_STAGES + 7 + 20;

  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
  localparam logic signed [31:0] HALF_PI   = 32'sd102944;
  localparam logic signed [31:0] PI_Q16    = 32'sd205887;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [COORD_WIDTH-1:0]  in_x_in = '0;
  logic signed [COORD_WIDTH-1:0]  in_y_in = '0;
  logic signed [COORD_WIDTH-1:0]  in_angle_in = '0;
  logic                           in_mode = vr2d_pkg::MODE_DEG;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [COORD_WIDTH-1:0]         out_x_out;
  logic [COORD_WIDTH-1:0]         out_y_out;

  int mismatches;
  int rotations_pending;
  int rotations_checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_sent = 0;

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vector_rotate_2d_unit #(
    .COORD_WIDTH  (COORD_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x_in    (in_x_in),
    .in_y_in    (in_y_in),
    .in_angle_in(in_angle_in),
    .in_mode    (in_mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x_out  (out_x_out),
    .out_y_out  (out_y_out)
  );

  vr2d_rotation_check #(
    .COORD_WIDTH  (COORD_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_rotation_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_x_in          (in_x_in),
    .in_y_in          (in_y_in),
    .in_angle_in      (in_angle_in),
    .in_mode          (in_mode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x_out        (out_x_out),
    .out_y_out        (out_y_out),
    .mismatches       (mismatches),
    .rotations_pending(rotations_pending),
    .rotations_checked(rotations_checked)
  );

  // Result side: stall at random according to the current phase.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Integer to Q15.16.
  function automatic logic signed [31:0] q16(input int val);
    return val * ONE_Q16;
  endfunction

  // Offer one input beat, with random idle cycles ahead of it, and hold it
  // until it is taken. Called and returns at a falling edge.
  task automatic send_vec(
    input logic signed [31:0] xv,
    input logic signed [31:0] yv,
    input logic signed [31:0] av,
    input logic               unit
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_x_in     <= xv;
    in_y_in     <= yv;
    in_angle_in <= av;
    in_mode     <= unit;
    do begin
      @(posedge clk);
    end while (!in_ready);
    beats_sent++;
    @(negedge clk);
  endtask

  // One random vector: mostly moderate magnitudes so results stay in range,
  // with full-range coordinates and angles mixed in to reach saturation and
  // deep phase wrap.
  task automatic send_random_vec();
    logic signed [31:0] xv;
    logic signed [31:0] yv;
    logic signed [31:0] av;
    logic               unit;
    int                 sel;
    unit = 1'($urandom_range(1));
    xv   = $urandom;
    yv   = $urandom;
    if ($urandom_range(9) < 7) begin
      xv = xv >>> $urandom_range(16, 1);
      yv = yv >>> $urandom_range(16, 1);
    end
    sel = $urandom_range(9);
    if (sel < 3) begin
      av = $urandom;
    end else if (sel < 8) begin
      if (unit == vr2d_pkg::MODE_DEG) begin
        av = $signed($urandom_range(2 * 720 * 65536)) - q16(720);
      end else begin
        av = $signed($urandom_range(2 * PI_Q16 * 4)) - PI_Q16 * 4;
      end
    end else begin
      av   = q16(90 * ($signed($urandom_range(16)) - 8));
      unit = vr2d_pkg::MODE_DEG;
    end
    send_vec(xv, yv, av, unit);
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: coordinate extremes, quarter turns, wrap and saturation.
    send_vec(32'sd0, 32'sd0, 32'sd0, vr2d_pkg::MODE_DEG);
    send_vec(q16(1), 32'sd0, 32'sd0, vr2d_pkg::MODE_DEG);
    send_vec(q16(1), 32'sd0, q16(90), vr2d_pkg::MODE_DEG);
    send_vec(q16(1), q16(2), q16(180), vr2d_pkg::MODE_DEG);
    send_vec(q16(3), -q16(1), q16(270), vr2d_pkg::MODE_DEG);
    send_vec(q16(3), q16(4), -q16(90), vr2d_pkg::MODE_DEG);
    send_vec(q16(5), -q16(7), q16(360), vr2d_pkg::MODE_DEG);
    send_vec(q16(5), q16(7), q16(45), vr2d_pkg::MODE_DEG);
    send_vec(-q16(5), q16(7), -q16(1125), vr2d_pkg::MODE_DEG);
    send_vec(q16(1), q16(1), HALF_PI, vr2d_pkg::MODE_RAD);
    send_vec(q16(1), -q16(1), PI_Q16, vr2d_pkg::MODE_RAD);
    send_vec(q16(2), q16(1), -HALF_PI, vr2d_pkg::MODE_RAD);
    send_vec(COORD_MAX, COORD_MAX, q16(45), vr2d_pkg::MODE_DEG);
    send_vec(COORD_MIN, COORD_MIN, q16(45), vr2d_pkg::MODE_DEG);
    send_vec(COORD_MAX, COORD_MIN, -q16(45), vr2d_pkg::MODE_DEG);
    send_vec(COORD_MIN, 32'sd0, q16(180), vr2d_pkg::MODE_DEG);
    send_vec(COORD_MIN, COORD_MAX, q16(90), vr2d_pkg::MODE_DEG);
    send_vec(-32'sd1, 32'sd1, q16(30), vr2d_pkg::MODE_DEG);
    send_vec(q16(100), q16(-50), COORD_MAX, vr2d_pkg::MODE_DEG);
    send_vec(q16(100), q16(-50), COORD_MIN, vr2d_pkg::MODE_DEG);
    send_vec(q16(100), q16(-50), COORD_MAX, vr2d_pkg::MODE_RAD);
    send_vec(q16(100), q16(-50), COORD_MIN, vr2d_pkg::MODE_RAD);
    send_vec(32'sd1, -32'sd1, -32'sd1, vr2d_pkg::MODE_RAD);

    // Random: free flow, sender idling, receiver stalling, then both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      repeat (RANDOM_BEATS / 4) send_random_vec();
    end

    // Drain the pipeline.
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (rotations_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d vectors (corner cases, degrees and radians, wide angle wrap)",
             beats_sent);
    $display("under four flow-control phases; %0d rotated results checked, %0d mismatches.",
             rotations_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS vector_rotate_2d_unit");
    end else begin
      $display("FAIL vector_rotate_2d_unit");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #400000;
    $display("Timeout with %0d rotations still outstanding.", rotations_pending);
    $display("FAIL vector_rotate_2d_unit");
    $finish;
  end

endmodule

/* filelist.f */
rtl/vr2d_pkg.sv
rtl/vr2d_phase.sv
rtl/vr2d_cell.sv
rtl/vr2d_mix.sv
rtl/vector_rotate_2d_unit.sv
test/vr2d_rotation_check.sv
test/tb.sv
